FILE: sv/sjis_pkg.sv
// shared types and constants for the shift_jis to jis x0213 decoder
// no dependencies; imported by every module of the block

package sjis_pkg;

	localparam int BYTE_W = 8;
	localparam int CODE_W = 16;

	// byte classes of the shift_jis stream
	localparam logic [BYTE_W-1:0] SINGLE_LO_MAX = 8'h7F;
	localparam logic [BYTE_W-1:0] KANA_MIN      = 8'hA0;
	localparam logic [BYTE_W-1:0] KANA_MAX      = 8'hDF;
	localparam logic [BYTE_W-1:0] SINGLE_HI_MIN = 8'hFD;
	localparam logic [BYTE_W-1:0] BAD_LEAD      = 8'h80;

	// code given for a bad lead or trail byte
	localparam logic [CODE_W-1:0] ERR_CODE = 16'h003F;

	// decode of the byte in stage 1 against the held lead
	typedef struct packed {
		logic                emit;
		logic [CODE_W-1:0]   code;
		logic                pend;
		logic [BYTE_W-1:0]   lead;
	} dec_t;

endpackage

FILE: sv/sjis_byte_if.sv
// valid/ready channel carrying one raw shift_jis byte per beat
// depends on sjis_pkg

interface sjis_byte_if;
	logic                       valid;
	logic                       ready;
	logic [sjis_pkg::BYTE_W-1:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

FILE: sv/sjis_code_if.sv
// valid/ready channel carrying one 16-bit jis code per beat
// depends on sjis_pkg

interface sjis_code_if;
	logic                       valid;
	logic                       ready;
	logic [sjis_pkg::CODE_W-1:0] jis_code;

	modport source (output valid, output jis_code, input ready);
	modport sink   (input valid, input jis_code, output ready);
endinterface

FILE: sv/sjis_decode.sv
// combinational decode of one byte against the held lead byte
// depends on sjis_pkg

module sjis_decode (
	input  logic [sjis_pkg::BYTE_W-1:0] in_byte,
	input  logic                        pend,
	input  logic [sjis_pkg::BYTE_W-1:0] lead,
	output sjis_pkg::dec_t              dec
);
	import sjis_pkg::*;

	// lead/trail pair to plane, row+0x20, cell+0x20
	function automatic logic [CODE_W-1:0] decode_pair(input logic [BYTE_W-1:0] ld,
			input logic [BYTE_W-1:0] tr);
		logic              plane;
		logic [BYTE_W-1:0] row;
		logic [BYTE_W-1:0] cel;
		logic [CODE_W-1:0] res;
		plane = 1'b0;
		row   = '0;
		cel   = '0;
		if (ld >= 8'h81 && ld <= 8'h9F) begin
			row = ((ld - 8'h81) << 1) + 8'd1;
		end else if (ld >= 8'hE0 && ld <= 8'hEF) begin
			row = ((ld - 8'hE0) << 1) + 8'h3F;
		end else if (ld >= 8'hF0 && ld <= 8'hFC) begin
			plane = 1'b1;
			row   = ((ld - 8'hF0) << 1) + 8'd7;
			if (ld >= 8'hF4) begin
				row = row + 8'h3E;
			end
		end
		if (tr >= 8'h40 && tr < 8'h7F) begin
			cel = tr - 8'h3F;
		end else if (tr >= 8'h80 && tr < 8'h9F) begin
			cel = tr - 8'h40;
		end else if (tr >= 8'h9F && tr < 8'hFD) begin
			cel = tr - 8'h9E;
			row = row + 8'd1;
		end
		// plane 2 row remap
		if (plane) begin
			if (row == 8'h07) begin
				row = 8'h01;
			end else if (row == 8'h0B) begin
				row = 8'h05;
			end else if (row == 8'h4D) begin
				row = 8'h0F;
			end
		end
		if (row == '0 || cel == '0) begin
			res = ERR_CODE;
		end else begin
			res = {plane, row[6:0] + 7'h20, cel + 8'h20};
		end
		return res;
	endfunction

	logic is_single;

	assign is_single = (in_byte <= SINGLE_LO_MAX)
		|| (in_byte >= KANA_MIN && in_byte <= KANA_MAX)
		|| (in_byte >= SINGLE_HI_MIN);

	always_comb begin
		dec.emit = 1'b1;
		dec.code = {{(CODE_W-BYTE_W){1'b0}}, in_byte};
		dec.pend = 1'b0;
		dec.lead = '0;
		if (pend) begin
			dec.code = decode_pair(lead, in_byte);
		end else if (is_single) begin
			dec.code = {{(CODE_W-BYTE_W){1'b0}}, in_byte};
		end else if (in_byte == BAD_LEAD) begin
			dec.code = ERR_CODE;
		end else begin
			// lead byte: hold it, no result
			dec.emit = 1'b0;
			dec.pend = 1'b1;
			dec.lead = in_byte;
		end
	end

endmodule

FILE: sv/sjis_out_reg.sv
// result register driving the code channel
// depends on sjis_pkg and sjis_code_if

module sjis_out_reg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  logic [sjis_pkg::CODE_W-1:0] code,
	output logic                        space,
	sjis_code_if.source                 codes
);
	import sjis_pkg::*;

	logic              valid_q;
	logic [CODE_W-1:0] code_q;

	// free to load when empty or emptied this cycle
	assign space = !valid_q || codes.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (codes.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			code_q <= code;
		end
	end

	assign codes.valid    = valid_q;
	assign codes.jis_code = code_q;

endmodule

FILE: sv/sjis_to_jis_decoder_top.sv
// top level of the shift_jis-2004 to jis x0213 decoder
// depends on sjis_pkg, sjis_byte_if, sjis_code_if, sjis_decode, sjis_out_reg
//
// usage
// - bytes: one raw shift_jis byte per beat (valid/ready)
// - codes: one 16-bit jis code per beat (valid/ready)
// - a single-byte code or a stray 0x80 gives one code at once; a lead byte
//   gives nothing and is held, the next byte completes the pair and gives
//   one code; a bad trail byte gives 0x3F and drops the lead
// - a byte taken on bytes passes the input register, then decode into the
//   result register, before its code shows on codes
// - throughput: one byte per cycle while codes does not stall, set by the
//   single decode pass between the stage 1 register and the result register
// - reset (arst_n low): both registers empty, no lead held
// - when codes stalls, the full result register holds its beat; stage 1
//   still takes a byte and a lead byte passes on into the lead register,
//   so bytes backs up only once both registers hold work

module sjis_to_jis_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	sjis_byte_if.sink   bytes,
	sjis_code_if.source codes
);
	import sjis_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              pend_q;
	logic [BYTE_W-1:0] lead_q;
	dec_t              dec;
	logic              space;
	logic              adv_s1;
	logic              in_acc;

	// stage 1 moves on when its decode needs no slot or the slot is free
	assign adv_s1      = valid_s1 && (!dec.emit || space);
	assign bytes.ready = !valid_s1 || adv_s1;
	assign in_acc      = bytes.valid && bytes.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_acc || (valid_s1 && !adv_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1 <= bytes.in_byte;
		end
	end

	// held lead byte, updated as each byte leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			lead_q <= '0;
		end else if (adv_s1) begin
			pend_q <= dec.pend;
			lead_q <= dec.lead;
		end
	end

	sjis_decode u_decode (
		.in_byte (byte_s1),
		.pend    (pend_q),
		.lead    (lead_q),
		.dec     (dec)
	);

	sjis_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (adv_s1 && dec.emit),
		.code   (dec.code),
		.space  (space),
		.codes  (codes)
	);

	// a lead byte leaving stage 1 is held next cycle
	a_lead_held: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && !pend_q && !dec.emit) |=> pend_q)
		else $error("lead byte not held");

	// a completed pair always drops the held lead
	a_pair_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && pend_q) |=> !pend_q)
		else $error("lead still held after pair");

	// a new result beat only follows a byte leaving stage 1
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(codes.valid) |-> $past(adv_s1 && dec.emit))
		else $error("result beat without a decoded byte");

	// a lead byte never produces a result
	a_lead_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(dec.pend) |-> !dec.emit)
		else $error("lead byte emitted a result");

endmodule
